// ===== hw/rtl/clas_pkg.sv =====
// ----------------------------------------------------------------------------
// clas_pkg
// Shared types and constants for the cache line with aging statistics.
// ----------------------------------------------------------------------------
package clas_pkg;

  localparam int TAG_BITS      = 48;
  localparam int AGE_BITS      = 8;
  localparam int COUNT_BITS    = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_AGE   = 2'd2;

  // Lookup status codes
  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_MATCH    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;

  // Configuration register indexes
  localparam logic REG_WRITE_BACK_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]          op;
    logic [TAG_BITS-1:0] req_tag;
    logic                touched;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            lookup_status;
    logic                  was_hit;
    logic                  evicted_dirty;
    logic [AGE_BITS-1:0]   age_value;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
    logic [COUNT_BITS-1:0] read_total;
    logic [COUNT_BITS-1:0] write_total;
    logic [COUNT_BITS-1:0] memread_total;
    logic [COUNT_BITS-1:0] memwrite_total;
  } out_item_t;

  // Counter increment strobes from the line core
  typedef struct packed {
    logic hit;
    logic miss;
    logic rd;
    logic wr;
    logic memrd;
    logic memwr;
  } cnt_inc_t;

endpackage

// ===== hw/rtl/cache_line_with_aging_stats.sv =====
// ----------------------------------------------------------------------------
// cache_line_with_aging_stats
// One cache line with an aging register and saturating traffic counters.
// ----------------------------------------------------------------------------
// Accepts one transaction (read, write or age tick) per clock unless the output
// stalls, and returns one result per transaction: the transaction is captured
// in an input register, the line core and the six counters update when it
// leaves that register, and the result lands in an output register at that
// same edge. Throughput is one transaction per cycle while the output is not
// stalled, limited by the single line-state update per cycle; a stalled output
// holds the pipe without losing anything. The write_back_mode register (byte
// address 0, reset 1) should be changed only while no transaction is in flight.
module cache_line_with_aging_stats import clas_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  logic                  wb_mode_r;
  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  s1_adv;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;
  cnt_inc_t              inc;
  logic [1:0]            status;
  logic                  hit;
  logic                  evicted;
  logic [AGE_BITS-1:0]   age_nxt;
  logic [COUNT_BITS-1:0] hit_nxt, miss_nxt, rd_nxt, wr_nxt, memrd_nxt, memwr_nxt;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_WRITE_BACK_MODE) ?
                      {{(CFG_DATA_BITS-1){1'b0}}, wb_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_WRITE_BACK_MODE)) begin
      wb_mode_r <= cfg_pwdata[0];
    end
  end

  // Pipe control: stage 1 advances when the output register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  clas_line_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (s1_adv),
    .item    (s1_item_r),
    .wb_mode (wb_mode_r),
    .inc     (inc),
    .status  (status),
    .hit     (hit),
    .evicted (evicted),
    .age_nxt (age_nxt)
  );

  clas_sat_cnt u_hit_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.hit), .count_nxt(hit_nxt));
  clas_sat_cnt u_miss_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.miss), .count_nxt(miss_nxt));
  clas_sat_cnt u_rd_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.rd), .count_nxt(rd_nxt));
  clas_sat_cnt u_wr_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.wr), .count_nxt(wr_nxt));
  clas_sat_cnt u_memrd_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.memrd), .count_nxt(memrd_nxt));
  clas_sat_cnt u_memwr_cnt (
    .clk(clk), .rst_n(rst_n), .inc(inc.memwr), .count_nxt(memwr_nxt));

  // Assemble the result from the post-step state
  always_comb begin
    out_data_nxt.lookup_status  = status;
    out_data_nxt.was_hit        = hit;
    out_data_nxt.evicted_dirty  = evicted;
    out_data_nxt.age_value      = age_nxt;
    out_data_nxt.hit_total      = hit_nxt;
    out_data_nxt.miss_total     = miss_nxt;
    out_data_nxt.read_total     = rd_nxt;
    out_data_nxt.write_total    = wr_nxt;
    out_data_nxt.memread_total  = memrd_nxt;
    out_data_nxt.memwrite_total = memwr_nxt;
  end

  // Output register: load on advance, drop on handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/clas_sat_cnt.sv =====
// ----------------------------------------------------------------------------
// clas_sat_cnt
// Saturating traffic counter; exposes the value after this cycle's update.
// ----------------------------------------------------------------------------
module clas_sat_cnt import clas_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  inc,
  output logic [COUNT_BITS-1:0] count_nxt
);

  logic [COUNT_BITS-1:0] count_r;

  // Advance unless already at the maximum
  always_comb begin
    count_nxt = count_r;
    if (inc && (count_r != {COUNT_BITS{1'b1}})) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/clas_line_core.sv =====
// ----------------------------------------------------------------------------
// clas_line_core
// Line state (tag, valid, dirty, aging) and the per-transaction decision logic.
// ----------------------------------------------------------------------------
module clas_line_core import clas_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  in_item_t            item,
  input  logic                wb_mode,
  output cnt_inc_t            inc,
  output logic [1:0]          status,
  output logic                hit,
  output logic                evicted,
  output logic [AGE_BITS-1:0] age_nxt
);

  logic [TAG_BITS-1:0] tag_r;
  logic [TAG_BITS-1:0] tag_nxt;
  logic                valid_r;
  logic                valid_nxt;
  logic                dirty_r;
  logic                dirty_nxt;
  logic [AGE_BITS-1:0] age_r;
  logic                match;
  logic                is_rd;
  logic                is_wr;
  logic                miss;

  // Compare the tag and classify the transaction
  always_comb begin
    match   = valid_r && (item.req_tag == tag_r);
    is_rd   = (item.op == OP_READ);
    is_wr   = (item.op == OP_WRITE);
    miss    = (is_rd || is_wr) && !match;
    hit     = (is_rd || is_wr) && match;
    evicted = miss && dirty_r && wb_mode;
    if (!valid_r) begin
      status = ST_INVALID;
    end else if (match) begin
      status = ST_MATCH;
    end else begin
      status = ST_MISMATCH;
    end
  end

  // Drive counter strobes
  always_comb begin
    inc.hit   = go && hit;
    inc.miss  = go && miss;
    inc.rd    = go && is_rd;
    inc.wr    = go && is_wr;
    inc.memrd = go && miss;
    inc.memwr = go && (evicted || (is_wr && !wb_mode));
  end

  // Refill on a miss, mark dirty on a write, shift the aging register on a tick
  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    age_nxt   = age_r;
    if (miss) begin
      tag_nxt   = item.req_tag;
      valid_nxt = 1'b1;
      dirty_nxt = 1'b0;
      age_nxt   = '0;
    end
    if (is_wr) begin
      dirty_nxt = 1'b1;
    end
    if (item.op == OP_AGE) begin
      age_nxt = {item.touched, age_r[AGE_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      age_r   <= '0;
    end else if (go) begin
      tag_r   <= tag_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      age_r   <= age_nxt;
    end
  end

endmodule

// ===== hw/rtl/clas_checker.sv =====
// ----------------------------------------------------------------------------
// clas_checker
// Port-level checks for the cache line with aging statistics.
// ----------------------------------------------------------------------------
module clas_checker import clas_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A hit needs a matching tag and a nonzero hit count
  a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_hit |->
      out_data.lookup_status == ST_MATCH && out_data.hit_total != '0)
    else $error("hit without tag match or hit count");

  // A dirty eviction is a miss that counted a memory write and read
  a_evict_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted_dirty |->
      !out_data.was_hit && out_data.memwrite_total != '0 &&
      out_data.memread_total != '0 && out_data.lookup_status == ST_MISMATCH)
    else $error("dirty eviction inconsistent with counters");

endmodule

bind cache_line_with_aging_stats clas_checker u_clas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single cache line with aging statistics.
// ----------------------------------------------------------------------------
// Drives read, write, age-tick and unused-op transactions with random gaps
// and output back-pressure. A scoreboard class keeps its own copy of the line
// and its counters and predicts each lookup result. Every returned result is
// checked field by field against the oldest prediction. The write-back mode
// register is changed between phases, only while nothing is in flight, and
// is read back after each write.
module testbench;
  import clas_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         STALL_PCT  = 11;
  localparam int         HANG_LIMIT = 1000;
  localparam int         PHASE_LEN  = 170;

  // Predicts the lookup result of every transaction and checks what returns
  class line_stats_board;
    logic                  write_back;
    logic [TAG_BITS-1:0]   line_tag;
    logic                  line_valid;
    logic                  line_dirty;
    logic [AGE_BITS-1:0]   age;
    logic [COUNT_BITS-1:0] hits, misses, reads, writes, mem_rd_total, mem_wr_total;
    out_item_t             expected_lookups[$];
    int                    errors;

    function new();
      write_back   = 1'b1;
      line_tag     = '0;
      line_valid   = 1'b0;
      line_dirty   = 1'b0;
      age          = '0;
      hits         = '0;
      misses       = '0;
      reads        = '0;
      writes       = '0;
      mem_rd_total = '0;
      mem_wr_total = '0;
      errors       = 0;
    endfunction

    function logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + COUNT_BITS'(1);
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        log_error($sformatf("mismatch %s: expected 0x%0h got 0x%0h", field, want, got));
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // Advance the line state for one accepted transaction, queue its result
    function void predict_access(in_item_t req);
      out_item_t res;
      logic      match;
      res   = '0;
      match = line_valid && (req.req_tag == line_tag);
      res.lookup_status = !line_valid ? ST_INVALID : (match ? ST_MATCH : ST_MISMATCH);
      if (req.op == OP_READ || req.op == OP_WRITE) begin
        if (match) begin
          res.was_hit = 1'b1;
          hits = sat_inc(hits);
        end else begin
          // refill: write back a dirty line only in write-back mode
          if (line_dirty && write_back) begin
            res.evicted_dirty = 1'b1;
            mem_wr_total = sat_inc(mem_wr_total);
          end
          mem_rd_total = sat_inc(mem_rd_total);
          misses       = sat_inc(misses);
          line_tag     = req.req_tag;
          line_valid   = 1'b1;
          line_dirty   = 1'b0;
          age          = '0;
        end
        if (req.op == OP_READ) begin
          reads = sat_inc(reads);
        end else begin
          writes = sat_inc(writes);
          if (!write_back) mem_wr_total = sat_inc(mem_wr_total);
          line_dirty = 1'b1;
        end
      end else if (req.op == OP_AGE) begin
        age = {req.touched, age[AGE_BITS-1:1]};
      end
      res.age_value      = age;
      res.hit_total      = hits;
      res.miss_total     = misses;
      res.read_total     = reads;
      res.write_total    = writes;
      res.memread_total  = mem_rd_total;
      res.memwrite_total = mem_wr_total;
      expected_lookups.push_back(res);
    endfunction

    // Compare one returned result with the oldest prediction
    function void check_lookup(out_item_t got);
      out_item_t want;
      if (expected_lookups.size() == 0) begin
        log_error($sformatf("unexpected result 0x%0h", got));
        return;
      end
      want = expected_lookups.pop_front();
      compare("lookup_status",  64'(want.lookup_status),  64'(got.lookup_status));
      compare("was_hit",        64'(want.was_hit),        64'(got.was_hit));
      compare("evicted_dirty",  64'(want.evicted_dirty),  64'(got.evicted_dirty));
      compare("age_value",      64'(want.age_value),      64'(got.age_value));
      compare("hit_total",      64'(want.hit_total),      64'(got.hit_total));
      compare("miss_total",     64'(want.miss_total),     64'(got.miss_total));
      compare("read_total",     64'(want.read_total),     64'(got.read_total));
      compare("write_total",    64'(want.write_total),    64'(got.write_total));
      compare("memread_total",  64'(want.memread_total),  64'(got.memread_total));
      compare("memwrite_total", 64'(want.memwrite_total), 64'(got.memwrite_total));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_item_t                out_data;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  line_stats_board     board = new();
  logic                calm = 1'b0;
  logic [TAG_BITS-1:0] tag_pool [4];
  int                  idle_cycles = 0;

  cache_line_with_aging_stats u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Throttle the result side except during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_lookup(out_data);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_req(logic [1:0] op, logic [TAG_BITS-1:0] tag,
                                        logic touched);
    in_item_t r;
    r.op      = op;
    r.req_tag = tag;
    r.touched = touched;
    return r;
  endfunction

  // Mostly accesses to a few recurring tags so hits and evictions happen
  function automatic in_item_t random_req();
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(99);
    op = (pick < 40) ? OP_READ : (pick < 75) ? OP_WRITE : (pick < 95) ? OP_AGE : OP_UNUSED;
    if ($urandom_range(99) < 75)
      return make_req(op, tag_pool[2'($urandom_range(3))], 1'($urandom_range(1)));
    return make_req(op, TAG_BITS'({$urandom(), $urandom()}), 1'($urandom_range(1)));
  endfunction

  // Present one transaction, hold it until accepted, then predict its result
  task automatic send_req(input in_item_t req);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.predict_access(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write the mode register over the config port, then read it back
  task automatic set_write_back(input logic mode);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BITS'(REG_WRITE_BACK_MODE) << 2;
    cfg_pwdata  <= CFG_DATA_BITS'(mode);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    board.write_back = mode;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    board.compare("write_back_mode readback", 64'(mode), 64'(cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    in_item_t   directed[$];
    logic [1:0] modes[4];
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    tag_pool[2] = TAG_BITS'({$urandom(), $urandom()});
    tag_pool[3] = TAG_BITS'({$urandom(), $urandom()});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk in the reset mode (write-back)
    directed = '{
      make_req(OP_AGE,    '0, 1'b1),   // tick on an invalid line
      make_req(OP_READ,   '0, 1'b0),   // cold miss clears the age
      make_req(OP_READ,   '0, 1'b1),   // read hit
      make_req(OP_WRITE,  '0, 1'b0),   // write hit marks dirty
      make_req(OP_AGE,    '1, 1'b1),
      make_req(OP_AGE,    '0, 1'b1),
      make_req(OP_AGE,    '0, 1'b0),
      make_req(OP_UNUSED, '1, 1'b1),   // unused op on a mismatch
      make_req(OP_READ,   '1, 1'b0),   // read miss evicts the dirty line
      make_req(OP_WRITE,  '0, 1'b1),   // write miss on a clean line
      make_req(OP_WRITE,  '1, 1'b0),   // write miss evicts dirty
      make_req(OP_UNUSED, '1, 1'b0),   // unused op on a match
      make_req(OP_AGE,    '1, 1'b1),
      make_req(OP_WRITE,  '1, 1'b1),
      make_req(OP_READ,   '1, 1'b0)
    };
    foreach (directed[i]) send_req(directed[i]);

    // Random phases across both modes; the third runs with no idling
    modes = '{2'd0, 2'd1, 2'd0, 2'd1};
    foreach (modes[p]) begin
      drain();
      set_write_back(modes[p][0]);
      calm = (p == 2);
      if (p == 0) begin
        send_req(make_req(OP_WRITE, tag_pool[2], 1'b0));   // write-through miss
        send_req(make_req(OP_WRITE, tag_pool[2], 1'b1));   // write-through hit
      end
      repeat (PHASE_LEN) send_req(random_req());
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
